// ----- rtl/vec3a_pkg.sv -----
package vec3a_pkg;

  localparam int WORD = 32;
  localparam int FRAC = 16;
  localparam int PROD = 2 * WORD;
  localparam int QW = PROD - 1;
  localparam int REM_W = WORD + 2;
  localparam int SQ_STEPS = WORD;
  localparam int DIV_STEPS = QW;
  localparam int LANES = 3;

  typedef logic signed [WORD-1:0] word_t;
  typedef logic signed [PROD-1:0] prod_t;

  localparam word_t WMAX = word_t'({1'b0, {(WORD-1){1'b1}}});
  localparam word_t WMIN = word_t'({1'b1, {(WORD-1){1'b0}}});
  localparam word_t FRAC_ONE = word_t'(1) <<< FRAC;

  typedef enum logic [3:0] {
    OP_ADD    = 4'd0,
    OP_SUB    = 4'd1,
    OP_MUL    = 4'd2,
    OP_SCALE  = 4'd3,
    OP_DIV    = 4'd4,
    OP_ADDS   = 4'd5,
    OP_CROSS  = 4'd6,
    OP_DOT    = 4'd7,
    OP_MAG    = 4'd8,
    OP_SETLEN = 4'd9,
    OP_NEG    = 4'd10
  } op_t;

  typedef enum logic [1:0] {
    ST_OK  = 2'd0,
    ST_SAT = 2'd1,
    ST_DZ  = 2'd2
  } status_t;

  typedef struct packed {
    logic [3:0] op;
    word_t      a_x;
    word_t      a_y;
    word_t      a_z;
    word_t      b_x;
    word_t      b_y;
    word_t      b_z;
    word_t      s;
  } in_t;

  typedef struct packed {
    logic [3:0]                 op;
    word_t                      r_x;
    word_t                      r_y;
    word_t                      r_z;
    word_t                      so;
    status_t                    st;
    logic [LANES-1:0]           neg;
    logic [LANES-1:0][QW-1:0]   num;
    logic [WORD-1:0]            s_abs;
    logic                       s_zero;
  } side_t;

  function automatic logic over(input prod_t v);
    return !((&v[PROD-1:WORD-1]) || !(|v[PROD-1:WORD-1]));
  endfunction

  function automatic word_t clip(input prod_t v);
    if (over(v)) begin
      return v[PROD-1] ? WMIN : WMAX;
    end
    return v[WORD-1:0];
  endfunction

endpackage

// ----- rtl/vec3a_in_if.sv -----
interface vec3a_in_if;
  logic                  valid;
  logic                  ready;
  logic [3:0]            op;
  vec3a_pkg::word_t      a_x;
  vec3a_pkg::word_t      a_y;
  vec3a_pkg::word_t      a_z;
  vec3a_pkg::word_t      b_x;
  vec3a_pkg::word_t      b_y;
  vec3a_pkg::word_t      b_z;
  vec3a_pkg::word_t      scalar_in;

  modport source (output valid, op, a_x, a_y, a_z, b_x, b_y, b_z, scalar_in, input ready);
  modport sink (input valid, op, a_x, a_y, a_z, b_x, b_y, b_z, scalar_in, output ready);
endinterface

// ----- rtl/vec3a_out_if.sv -----
interface vec3a_out_if;
  logic                  valid;
  logic                  ready;
  vec3a_pkg::word_t      r_x;
  vec3a_pkg::word_t      r_y;
  vec3a_pkg::word_t      r_z;
  vec3a_pkg::word_t      scalar_out;
  logic [1:0]            status;

  modport source (output valid, r_x, r_y, r_z, scalar_out, status, input ready);
  modport sink (input valid, r_x, r_y, r_z, scalar_out, status, output ready);
endinterface

// ----- rtl/vec3a_front.sv -----
module vec3a_front (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      en,
  input  logic                      in_v,
  input  vec3a_pkg::in_t            in_d,
  output logic                      out_v,
  output logic [vec3a_pkg::PROD-1:0] out_rad,
  output vec3a_pkg::side_t          out_side
);

  logic                 v1;
  vec3a_pkg::in_t       in1;
  logic                 v2;
  vec3a_pkg::in_t       in2;
  vec3a_pkg::prod_t     p [6];
  vec3a_pkg::prod_t     p_next [6];
  vec3a_pkg::word_t     simple [3];
  vec3a_pkg::word_t     simple_next [3];
  logic                 sflag;
  logic                 sflag_next;
  vec3a_pkg::side_t     side_next;
  logic [vec3a_pkg::PROD-1:0] rad_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      out_v <= 1'b0;
    end else if (en) begin
      v1 <= in_v;
      v2 <= v1;
      out_v <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      in1 <= in_d;
      in2 <= in1;
      p <= p_next;
      simple <= simple_next;
      sflag <= sflag_next;
      out_rad <= rad_next;
      out_side <= side_next;
    end
  end

  always_comb begin
    vec3a_pkg::word_t a [3];
    vec3a_pkg::word_t b [3];
    vec3a_pkg::word_t ma [6];
    vec3a_pkg::word_t mb [6];
    vec3a_pkg::prod_t sum;
    a[0] = in1.a_x;
    a[1] = in1.a_y;
    a[2] = in1.a_z;
    b[0] = in1.b_x;
    b[1] = in1.b_y;
    b[2] = in1.b_z;
    for (int k = 0; k < 3; k++) begin
      ma[k] = a[k];
      mb[k] = b[k];
      ma[k+3] = a[k];
      mb[k+3] = a[k];
    end
    unique case (in1.op)
      vec3a_pkg::OP_SCALE, vec3a_pkg::OP_SETLEN: begin
        for (int k = 0; k < 3; k++) mb[k] = in1.s;
      end
      vec3a_pkg::OP_DIV: begin
        for (int k = 0; k < 3; k++) mb[k] = vec3a_pkg::FRAC_ONE;
      end
      vec3a_pkg::OP_CROSS: begin
        ma[0] = a[1]; mb[0] = b[2];
        ma[1] = a[2]; mb[1] = b[1];
        ma[2] = a[2]; mb[2] = b[0];
        ma[3] = a[0]; mb[3] = b[2];
        ma[4] = a[0]; mb[4] = b[1];
        ma[5] = a[1]; mb[5] = b[0];
      end
      default: begin
      end
    endcase
    for (int k = 0; k < 6; k++) begin
      p_next[k] = vec3a_pkg::prod_t'(ma[k]) * vec3a_pkg::prod_t'(mb[k]);
    end
    sflag_next = 1'b0;
    for (int k = 0; k < 3; k++) begin
      unique case (in1.op)
        vec3a_pkg::OP_ADD:  sum = vec3a_pkg::prod_t'(a[k]) + vec3a_pkg::prod_t'(b[k]);
        vec3a_pkg::OP_SUB:  sum = vec3a_pkg::prod_t'(a[k]) - vec3a_pkg::prod_t'(b[k]);
        vec3a_pkg::OP_ADDS: sum = vec3a_pkg::prod_t'(a[k]) + vec3a_pkg::prod_t'(in1.s);
        vec3a_pkg::OP_NEG:  sum = -vec3a_pkg::prod_t'(a[k]);
        default:            sum = '0;
      endcase
      simple_next[k] = vec3a_pkg::clip(sum);
      sflag_next = sflag_next | vec3a_pkg::over(sum);
    end
  end

  always_comb begin
    vec3a_pkg::prod_t fl [6];
    vec3a_pkg::prod_t pa;
    vec3a_pkg::prod_t d0;
    vec3a_pkg::prod_t d1;
    vec3a_pkg::prod_t d2;
    logic f;
    for (int k = 0; k < 6; k++) fl[k] = p[k] >>> vec3a_pkg::FRAC;
    side_next = '0;
    side_next.op = in2.op;
    side_next.st = vec3a_pkg::ST_OK;
    f = 1'b0;
    d0 = '0;
    d1 = '0;
    d2 = '0;
    unique case (in2.op)
      vec3a_pkg::OP_ADD, vec3a_pkg::OP_SUB, vec3a_pkg::OP_ADDS, vec3a_pkg::OP_NEG: begin
        side_next.r_x = simple[0];
        side_next.r_y = simple[1];
        side_next.r_z = simple[2];
        f = sflag;
      end
      vec3a_pkg::OP_MUL, vec3a_pkg::OP_SCALE: begin
        side_next.r_x = vec3a_pkg::clip(fl[0]);
        side_next.r_y = vec3a_pkg::clip(fl[1]);
        side_next.r_z = vec3a_pkg::clip(fl[2]);
        f = vec3a_pkg::over(fl[0]) | vec3a_pkg::over(fl[1]) | vec3a_pkg::over(fl[2]);
      end
      vec3a_pkg::OP_CROSS: begin
        d0 = fl[0] - fl[1];
        d1 = fl[2] - fl[3];
        d2 = fl[4] - fl[5];
        side_next.r_x = vec3a_pkg::clip(d0);
        side_next.r_y = vec3a_pkg::clip(d1);
        side_next.r_z = vec3a_pkg::clip(d2);
        f = vec3a_pkg::over(d0) | vec3a_pkg::over(d1) | vec3a_pkg::over(d2);
      end
      vec3a_pkg::OP_DOT: begin
        d0 = fl[0] + fl[1] + fl[2];
        side_next.so = vec3a_pkg::clip(d0);
        f = vec3a_pkg::over(d0);
      end
      default: begin
      end
    endcase
    side_next.st = f ? vec3a_pkg::ST_SAT : vec3a_pkg::ST_OK;
    for (int k = 0; k < vec3a_pkg::LANES; k++) begin
      pa = p[k][vec3a_pkg::PROD-1] ? -p[k] : p[k];
      side_next.num[k] = pa[vec3a_pkg::QW-1:0];
      side_next.neg[k] = p[k][vec3a_pkg::PROD-1] ^
                         ((in2.op == vec3a_pkg::OP_DIV) && in2.s[vec3a_pkg::WORD-1]);
    end
    side_next.s_abs = in2.s[vec3a_pkg::WORD-1] ? -in2.s : in2.s;
    side_next.s_zero = (in2.s == '0);
    rad_next = p[3] + p[4] + p[5];
  end

endmodule

// ----- rtl/vec3a_sqrt.sv -----
module vec3a_sqrt (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         en,
  input  logic                         in_v,
  input  logic [vec3a_pkg::PROD-1:0]   in_rad,
  input  vec3a_pkg::side_t             in_side,
  output logic                         out_v,
  output logic [vec3a_pkg::WORD-1:0]   out_root,
  output vec3a_pkg::side_t             out_side
);

  localparam int N = vec3a_pkg::SQ_STEPS;
  localparam int RW = vec3a_pkg::REM_W;

  logic                         v [N];
  logic [vec3a_pkg::PROD-1:0]   rad [N];
  logic [RW-1:0]                rem [N];
  logic [vec3a_pkg::WORD-1:0]   root [N];
  vec3a_pkg::side_t             side [N];
  logic [vec3a_pkg::PROD-1:0]   rad_next [N];
  logic [RW-1:0]                rem_next [N];
  logic [vec3a_pkg::WORD-1:0]   root_next [N];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < N; k++) v[k] <= 1'b0;
    end else if (en) begin
      v[0] <= in_v;
      for (int k = 1; k < N; k++) v[k] <= v[k-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rad <= rad_next;
      rem <= rem_next;
      root <= root_next;
      side[0] <= in_side;
      for (int k = 1; k < N; k++) side[k] <= side[k-1];
    end
  end

  always_comb begin
    logic [vec3a_pkg::PROD-1:0] rp;
    logic [RW-1:0]              mp;
    logic [vec3a_pkg::WORD-1:0] qp;
    logic [RW+1:0]              sh;
    logic [RW+1:0]              t;
    logic                       ge;
    for (int k = 0; k < N; k++) begin
      if (k == 0) begin
        rp = in_rad;
        mp = '0;
        qp = '0;
      end else begin
        rp = rad[k-1];
        mp = rem[k-1];
        qp = root[k-1];
      end
      sh = {mp, rp[vec3a_pkg::PROD-1 -: 2]};
      t = {2'b00, qp, 2'b01};
      ge = (sh >= t);
      rem_next[k] = ge ? RW'(sh - t) : sh[RW-1:0];
      root_next[k] = {qp[vec3a_pkg::WORD-2:0], ge};
      rad_next[k] = rp << 2;
    end
  end

  assign out_v = v[N-1];
  assign out_root = root[N-1];
  assign out_side = side[N-1];

endmodule

// ----- rtl/vec3a_div.sv -----
module vec3a_div (
  input  logic                                              clk,
  input  logic                                              rst,
  input  logic                                              en,
  input  logic                                              in_v,
  input  logic [vec3a_pkg::WORD-1:0]                        in_root,
  input  vec3a_pkg::side_t                                  in_side,
  output logic                                              out_v,
  output logic [vec3a_pkg::LANES-1:0][vec3a_pkg::QW-1:0]    out_q,
  output vec3a_pkg::side_t                                  out_side
);

  localparam int N = vec3a_pkg::DIV_STEPS;
  localparam int L = vec3a_pkg::LANES;
  localparam int W = vec3a_pkg::WORD;
  localparam int Q = vec3a_pkg::QW;

  logic                       ve;
  logic [W-1:0]               de;
  vec3a_pkg::side_t           se;
  vec3a_pkg::side_t           se_next;
  logic                       v [N];
  logic [W-1:0]               d [N];
  logic [L-1:0][Q-1:0]        nq [N];
  logic [L-1:0][W-1:0]        rem [N];
  vec3a_pkg::side_t           side [N];
  logic [L-1:0][Q-1:0]        nq_next [N];
  logic [L-1:0][W-1:0]        rem_next [N];

  always_ff @(posedge clk) begin
    if (rst) begin
      ve <= 1'b0;
      for (int k = 0; k < N; k++) v[k] <= 1'b0;
    end else if (en) begin
      ve <= in_v;
      v[0] <= ve;
      for (int k = 1; k < N; k++) v[k] <= v[k-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      de <= (in_side.op == vec3a_pkg::OP_SETLEN) ? in_root : in_side.s_abs;
      se <= se_next;
      d[0] <= de;
      side[0] <= se;
      for (int k = 1; k < N; k++) begin
        d[k] <= d[k-1];
        side[k] <= side[k-1];
      end
      nq <= nq_next;
      rem <= rem_next;
    end
  end

  always_comb begin
    se_next = in_side;
    if (in_side.op == vec3a_pkg::OP_MAG) begin
      se_next.so = in_root[W-1] ? vec3a_pkg::WMAX : vec3a_pkg::word_t'(in_root);
      se_next.st = in_root[W-1] ? vec3a_pkg::ST_SAT : vec3a_pkg::ST_OK;
    end
    if ((in_side.op == vec3a_pkg::OP_DIV && in_side.s_zero) ||
        (in_side.op == vec3a_pkg::OP_SETLEN && in_root == '0)) begin
      se_next.st = vec3a_pkg::ST_DZ;
    end
  end

  always_comb begin
    logic [Q-1:0]  np;
    logic [W-1:0]  mp;
    logic [W-1:0]  dp;
    logic [W:0]    sh;
    logic          ge;
    for (int k = 0; k < N; k++) begin
      dp = (k == 0) ? de : d[k-1];
      for (int l = 0; l < L; l++) begin
        np = (k == 0) ? se.num[l] : nq[k-1][l];
        mp = (k == 0) ? '0 : rem[k-1][l];
        sh = {mp, np[Q-1]};
        ge = (sh >= {1'b0, dp});
        rem_next[k][l] = ge ? W'(sh - {1'b0, dp}) : sh[W-1:0];
        nq_next[k][l] = {np[Q-2:0], ge};
      end
    end
  end

  assign out_v = v[N-1];
  assign out_q = nq[N-1];
  assign out_side = side[N-1];

endmodule

// ----- rtl/vector3_alu_core.sv -----
// Channel  Modport  Payload
// req      sink     op, a_x, a_y, a_z, b_x, b_y, b_z, scalar_in
// rsp      source   r_x, r_y, r_z, scalar_out, status
//
// One item enters per cycle while rsp does not stall, and its result passes through
// three front stages for the multipliers, 32 square root stages, one divisor select
// stage, 63 divider stages per lane and the output register.
// Reset is synchronous and clears only the valid bits of the pipeline.
// When a result waits on rsp the whole pipeline holds and req.ready is low.
module vector3_alu_core (
  input  logic         clk,
  input  logic         rst,
  vec3a_in_if.sink     req,
  vec3a_out_if.source  rsp
);

  logic                                                   en;
  vec3a_pkg::in_t                                         in_d;
  logic                                                   f_v;
  logic [vec3a_pkg::PROD-1:0]                             f_rad;
  vec3a_pkg::side_t                                       f_side;
  logic                                                   s_v;
  logic [vec3a_pkg::WORD-1:0]                             s_root;
  vec3a_pkg::side_t                                       s_side;
  logic                                                   d_v;
  logic [vec3a_pkg::LANES-1:0][vec3a_pkg::QW-1:0]         d_q;
  vec3a_pkg::side_t                                       d_side;
  logic                                                   ov;
  vec3a_pkg::word_t                                       r [3];
  vec3a_pkg::word_t                                       r_next [3];
  vec3a_pkg::word_t                                       so;
  vec3a_pkg::word_t                                       so_next;
  vec3a_pkg::status_t                                     st;
  vec3a_pkg::status_t                                     st_next;

  assign en = !ov || rsp.ready;
  assign req.ready = en;

  assign in_d.op = req.op;
  assign in_d.a_x = req.a_x;
  assign in_d.a_y = req.a_y;
  assign in_d.a_z = req.a_z;
  assign in_d.b_x = req.b_x;
  assign in_d.b_y = req.b_y;
  assign in_d.b_z = req.b_z;
  assign in_d.s = req.scalar_in;

  vec3a_front u_front (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_v     (req.valid),
    .in_d     (in_d),
    .out_v    (f_v),
    .out_rad  (f_rad),
    .out_side (f_side)
  );

  vec3a_sqrt u_sqrt (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_v     (f_v),
    .in_rad   (f_rad),
    .in_side  (f_side),
    .out_v    (s_v),
    .out_root (s_root),
    .out_side (s_side)
  );

  vec3a_div u_div (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_v     (s_v),
    .in_root  (s_root),
    .in_side  (s_side),
    .out_v    (d_v),
    .out_q    (d_q),
    .out_side (d_side)
  );

  always_comb begin
    vec3a_pkg::prod_t val;
    logic f;
    val = '0;
    f = 1'b0;
    r_next[0] = d_side.r_x;
    r_next[1] = d_side.r_y;
    r_next[2] = d_side.r_z;
    so_next = d_side.so;
    st_next = d_side.st;
    if (d_side.st == vec3a_pkg::ST_DZ) begin
      for (int k = 0; k < 3; k++) r_next[k] = '0;
      so_next = '0;
    end else if (d_side.op == vec3a_pkg::OP_DIV || d_side.op == vec3a_pkg::OP_SETLEN) begin
      f = 1'b0;
      for (int k = 0; k < 3; k++) begin
        val = vec3a_pkg::prod_t'({1'b0, d_q[k]});
        if (d_side.neg[k]) val = -val;
        r_next[k] = vec3a_pkg::clip(val);
        f = f | vec3a_pkg::over(val);
      end
      so_next = '0;
      st_next = f ? vec3a_pkg::ST_SAT : vec3a_pkg::ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ov <= 1'b0;
    end else if (en) begin
      ov <= d_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      r <= r_next;
      so <= so_next;
      st <= st_next;
    end
  end

  assign rsp.valid = ov;
  assign rsp.r_x = r[0];
  assign rsp.r_y = r[1];
  assign rsp.r_z = r[2];
  assign rsp.scalar_out = so;
  assign rsp.status = st;

`ifndef SYNTH
  a_dz_zero: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && rsp.status == vec3a_pkg::ST_DZ |->
      rsp.r_x == '0 && rsp.r_y == '0 && rsp.r_z == '0 && rsp.scalar_out == '0)
    else $error("divide by zero result carries nonzero fields");

  a_sat_bound: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && rsp.status == vec3a_pkg::ST_SAT |->
      rsp.r_x == vec3a_pkg::WMAX || rsp.r_x == vec3a_pkg::WMIN ||
      rsp.r_y == vec3a_pkg::WMAX || rsp.r_y == vec3a_pkg::WMIN ||
      rsp.r_z == vec3a_pkg::WMAX || rsp.r_z == vec3a_pkg::WMIN ||
      rsp.scalar_out == vec3a_pkg::WMAX || rsp.scalar_out == vec3a_pkg::WMIN)
    else $error("saturation status without a clipped field");

  a_hold_pipe: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && !rsp.ready |=> rsp.valid && $stable(rsp.status) && $stable(d_v))
    else $error("pipeline moved while the output was stalled");
`endif

endmodule

// ----- tb/sv/tb_top.sv -----
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [31:0] x, y, z, so;
    logic [1:0]  st;
  } vres_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  vec3a_in_if  req ();
  vec3a_out_if rsp ();

  vector3_alu_core dut (.clk(clk), .rst(rst), .req(req), .rsp(rsp));

  always #2 clk = ~clk;

  vres_t expected_q[$];
  int    mismatches = 0;
  bit    sending = 1'b0;
  bit    rsp_stall_on = 1'b1;

  function automatic longint sat32(input longint v, inout bit f);
    if (v > 64'sd2147483647) begin
      f = 1'b1;
      return 64'sd2147483647;
    end
    if (v < -64'sd2147483648) begin
      f = 1'b1;
      return -64'sd2147483648;
    end
    return v;
  endfunction

  function automatic longint qmul(input longint a, input longint b);
    return (a * b) >>> vec3a_pkg::FRAC;
  endfunction

  function automatic longint isqrt(input logic [63:0] v);
    logic [63:0] r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return longint'(r);
  endfunction

  function automatic vres_t alu_predict(input logic [3:0] op, input longint a[3],
                                        input longint b[3], input longint s);
    vres_t  e;
    longint r[3];
    longint so, mag;
    logic [63:0] ss;
    bit f, dz;
    r = '{0, 0, 0};
    so = 0;
    f = 0;
    dz = 0;
    ss = 64'(a[0] * a[0]) + 64'(a[1] * a[1]) + 64'(a[2] * a[2]);
    case (op)
      vec3a_pkg::OP_ADD: for (int i = 0; i < 3; i++) r[i] = sat32(a[i] + b[i], f);
      vec3a_pkg::OP_SUB: for (int i = 0; i < 3; i++) r[i] = sat32(a[i] - b[i], f);
      vec3a_pkg::OP_MUL: for (int i = 0; i < 3; i++) r[i] = sat32(qmul(a[i], b[i]), f);
      vec3a_pkg::OP_SCALE: for (int i = 0; i < 3; i++) r[i] = sat32(qmul(a[i], s), f);
      vec3a_pkg::OP_DIV: begin
        if (s == 0) dz = 1;
        else for (int i = 0; i < 3; i++) r[i] = sat32((a[i] * 65536) / s, f);
      end
      vec3a_pkg::OP_ADDS: for (int i = 0; i < 3; i++) r[i] = sat32(a[i] + s, f);
      vec3a_pkg::OP_CROSS: begin
        r[0] = sat32(qmul(a[1], b[2]) - qmul(a[2], b[1]), f);
        r[1] = sat32(qmul(a[2], b[0]) - qmul(a[0], b[2]), f);
        r[2] = sat32(qmul(a[0], b[1]) - qmul(a[1], b[0]), f);
      end
      vec3a_pkg::OP_DOT:
        so = sat32(qmul(a[0], b[0]) + qmul(a[1], b[1]) + qmul(a[2], b[2]), f);
      vec3a_pkg::OP_MAG: so = sat32(isqrt(ss), f);
      vec3a_pkg::OP_SETLEN: begin
        mag = isqrt(ss);
        if (mag == 0) dz = 1;
        else for (int i = 0; i < 3; i++) r[i] = sat32((a[i] * s) / mag, f);
      end
      vec3a_pkg::OP_NEG: for (int i = 0; i < 3; i++) r[i] = sat32(-a[i], f);
      default: ;
    endcase
    if (dz) begin
      r = '{0, 0, 0};
      so = 0;
    end
    e.x = r[0][31:0];
    e.y = r[1][31:0];
    e.z = r[2][31:0];
    e.so = so[31:0];
    e.st = dz ? vec3a_pkg::ST_DZ : (f ? vec3a_pkg::ST_SAT : vec3a_pkg::ST_OK);
    return e;
  endfunction

  function automatic int gap_len();
    if ($urandom_range(0, 19) == 0) return $urandom_range(10, 40);
    if ($urandom_range(0, 2) == 0) return $urandom_range(1, 3);
    return 0;
  endfunction

  task automatic send_vec(input logic [3:0] op, input logic [31:0] ax, ay, az,
                          bx, by, bz, s);
    longint a[3], b[3];
    int g;
    g = sending ? gap_len() : 0;
    repeat (g) begin
      req.valid <= 1'b0;
      @(posedge clk);
    end
    req.valid <= 1'b1;
    req.op <= op;
    req.a_x <= ax;
    req.a_y <= ay;
    req.a_z <= az;
    req.b_x <= bx;
    req.b_y <= by;
    req.b_z <= bz;
    req.scalar_in <= s;
    a = '{longint'($signed(ax)), longint'($signed(ay)), longint'($signed(az))};
    b = '{longint'($signed(bx)), longint'($signed(by)), longint'($signed(bz))};
    do @(posedge clk); while (!req.ready);
    expected_q.push_back(alu_predict(op, a, b, longint'($signed(s))));
  endtask

  function automatic logic [31:0] rword();
    case ($urandom_range(0, 5))
      0: return 32'h7fffffff;
      1: return 32'h80000000;
      2: return 32'($signed($urandom_range(0, 400000)) - 200000);
      3: return 32'($signed($urandom_range(0, 2000)) - 1000) <<< 16;
      default: return $urandom;
    endcase
  endfunction

  task automatic test_directed();
    logic [31:0] mx, mn, one;
    mx = 32'h7fffffff;
    mn = 32'h80000000;
    one = 32'h00010000;
    for (int o = 0; o < 16; o++) send_vec(o[3:0], one, -one, 3 * one, 2 * one, one, -one, 2 * one);
    send_vec(vec3a_pkg::OP_ADD, mx, mn, mx, mx, mn, 0, 0);
    send_vec(vec3a_pkg::OP_SUB, mn, mx, 0, mx, mn, 1, 0);
    send_vec(vec3a_pkg::OP_MUL, mx, mn, mn, mx, mn, mx, 0);
    send_vec(vec3a_pkg::OP_SCALE, mx, mn, one, 0, 0, 0, mn);
    send_vec(vec3a_pkg::OP_DIV, one, mx, mn, 0, 0, 0, 0);
    send_vec(vec3a_pkg::OP_DIV, mx, mn, one, 0, 0, 0, 1);
    send_vec(vec3a_pkg::OP_DIV, mx, mn, one, 0, 0, 0, -one);
    send_vec(vec3a_pkg::OP_SETLEN, 0, 0, 0, 0, 0, 0, one);
    send_vec(vec3a_pkg::OP_SETLEN, mn, mn, mn, 0, 0, 0, mx);
    send_vec(vec3a_pkg::OP_NEG, mn, mx, 0, 0, 0, 0, 0);
    send_vec(vec3a_pkg::OP_MAG, mn, mn, mn, 0, 0, 0, 0);
  endtask

  task automatic test_random(input int n);
    logic [3:0] op;
    sending = 1'b1;
    for (int i = 0; i < n; i++) begin
      op = ($urandom_range(0, 15) == 0) ? 4'($urandom_range(11, 15)) : 4'($urandom_range(0, 10));
      if (i == n / 2) rsp_stall_on = 1'b0;
      if (i == 3 * n / 4) rsp_stall_on = 1'b1;
      send_vec(op, rword(), rword(), rword(), rword(), rword(), rword(),
               ($urandom_range(0, 15) == 0) ? 32'h0 : rword());
    end
  endtask

  int stall_left = 0;
  always @(posedge clk) begin
    if (rst) begin
      rsp.ready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      rsp.ready <= 1'b0;
    end else if (rsp_stall_on && $urandom_range(0, 4) == 0) begin
      stall_left <= gap_len();
      rsp.ready <= 1'b0;
    end else begin
      rsp.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    vres_t e;
    if (!rst && rsp.valid && rsp.ready) begin
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("Unexpected transfer on the result channel");
      end else begin
        e = expected_q.pop_front();
        if (rsp.r_x !== e.x || rsp.r_y !== e.y || rsp.r_z !== e.z ||
            rsp.scalar_out !== e.so || rsp.status !== e.st) begin
          mismatches++;
          if (mismatches <= 10)
            $display("Mismatch: expected %h %h %h %h %0d, got %h %h %h %h %0d",
                     e.x, e.y, e.z, e.so, e.st, rsp.r_x, rsp.r_y, rsp.r_z,
                     rsp.scalar_out, rsp.status);
        end
      end
    end
  end

  initial begin
    req.valid = 1'b0;
    req.op = '0;
    req.a_x = '0;
    req.a_y = '0;
    req.a_z = '0;
    req.b_x = '0;
    req.b_y = '0;
    req.b_z = '0;
    req.scalar_in = '0;
    rsp.ready = 1'b0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_random(550);
    req.valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (120) @(posedge clk);
    if (mismatches == 0 && expected_q.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin
    #2ms;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end
endmodule
